/* rtl/wfd_pkg.sv */
// shared types and constants for the websocket frame deframer
// no dependencies; imported by every module of the block
package wfd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

	// opcodes the parser lets through
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;

	// 7-bit length codes
	localparam logic [6:0] LEN7_MAX  = 7'd125;
	localparam logic [6:0] LEN7_EXT2 = 7'd126;

	// byte counts for header fields; an 8-byte length wraps to zero in three bits
	localparam logic [2:0] EXT2_CNT = 3'd2;
	localparam logic [2:0] EXT8_CNT = 3'd0;
	localparam logic [2:0] KEY_CNT  = 3'd4;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_BADOP = 2'd2,
		KIND_LEN   = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_HDR1 = 6'b000001,
		PH_HDR2 = 6'b000010,
		PH_EXT  = 6'b000100,
		PH_KEY  = 6'b001000,
		PH_DATA = 6'b010000,
		PH_ERR  = 6'b100000
	} phase_t;

	// one classified result on its way to the back end
	typedef struct packed {
		kind_t      kind;
		logic [7:0] raw;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       last;
	} cmd_t;

endpackage

/* rtl/wfd_parser.sv */
// front end: frame header parser, turns each accepted byte into at most one command
// depends on wfd_pkg
module wfd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          q_push,
	output wfd_pkg::cmd_t q_cmd
);
	import wfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [2:0]  count_q, count_d;
	logic [15:0] len_q, len_d;
	logic        ovf_q, ovf_d;
	logic [31:0] key_q, key_d;
	logic [15:0] left_q, left_d;
	logic [1:0]  idx_q, idx_d;
	logic [15:0] max_q;

	logic        take;
	logic        push;
	cmd_t        cmd;
	logic [15:0] len_n;
	logic        ovf_n;
	logic        masked_n;
	logic        len_end;
	logic        hdr_end;
	logic [15:0] pay_len;
	logic [2:0]  count_m1;
	logic [15:0] left_m1;
	logic [7:0]  key_byte;

	// error phase drains input without needing queue room
	assign in_ready = !q_full || (phase_q == PH_ERR);
	assign take     = in_valid && in_ready;
	assign count_m1 = count_q - 3'd1;
	assign left_m1  = left_q - 16'd1;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		count_d  = count_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		key_d    = key_q;
		left_d   = left_q;
		idx_d    = idx_q;
		push     = 1'b0;
		cmd      = '{kind: KIND_DATA, raw: 8'd0, key: 8'd0, opcode: opcode_q, last: 1'b1};
		len_n    = len_q;
		ovf_n    = ovf_q;
		masked_n = masked_q;
		len_end  = 1'b0;
		hdr_end  = 1'b0;
		pay_len  = len_q;

		case (phase_q)
			PH_HDR1: begin
				if (in_byte[3:0] inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE}) begin
					opcode_d = in_byte[3:0];
					phase_d  = PH_HDR2;
				end else begin
					phase_d    = PH_ERR;
					push       = 1'b1;
					cmd.kind   = KIND_BADOP;
					cmd.opcode = in_byte[3:0];
				end
			end
			PH_HDR2: begin
				masked_n = in_byte[7];
				masked_d = in_byte[7];
				ovf_n    = 1'b0;
				ovf_d    = 1'b0;
				if (in_byte[6:0] <= LEN7_MAX) begin
					len_n   = {9'd0, in_byte[6:0]};
					len_d   = len_n;
					len_end = 1'b1;
				end else begin
					len_d   = 16'd0;
					count_d = (in_byte[6:0] == LEN7_EXT2) ? EXT2_CNT : EXT8_CNT;
					phase_d = PH_EXT;
				end
			end
			PH_EXT: begin
				ovf_n   = ovf_q || (len_q[15:8] != 8'd0);
				len_n   = {len_q[7:0], in_byte};
				ovf_d   = ovf_n;
				len_d   = len_n;
				count_d = count_m1;
				len_end = (count_m1 == 3'd0);
			end
			PH_KEY: begin
				key_d   = {key_q[23:0], in_byte};
				count_d = count_m1;
				hdr_end = (count_m1 == 3'd0);
			end
			PH_DATA: begin
				push     = 1'b1;
				cmd.raw  = in_byte;
				cmd.key  = masked_q ? key_byte : 8'd0;
				cmd.last = (left_m1 == 16'd0);
				idx_d    = idx_q + 2'd1;
				left_d   = left_m1;
				if (left_m1 == 16'd0) begin
					phase_d = PH_HDR1;
				end
			end
			default: begin
				phase_d = PH_ERR;
			end
		endcase

		// length field complete: range check, then mask key or payload
		if (len_end) begin
			if (ovf_n || (len_n > max_q)) begin
				phase_d  = PH_ERR;
				push     = 1'b1;
				cmd.kind = KIND_LEN;
			end else if (masked_n) begin
				key_d   = 32'd0;
				count_d = KEY_CNT;
				phase_d = PH_KEY;
			end else begin
				key_d   = 32'd0;
				hdr_end = 1'b1;
				pay_len = len_n;
			end
		end

		// header complete: start payload or report an empty frame
		if (hdr_end) begin
			idx_d  = 2'd0;
			left_d = pay_len;
			if (pay_len == 16'd0) begin
				phase_d  = PH_HDR1;
				push     = 1'b1;
				cmd.kind = KIND_EMPTY;
			end else begin
				phase_d = PH_DATA;
			end
		end
	end

	assign q_push = take && push;
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			count_q  <= 3'd0;
			len_q    <= 16'd0;
			ovf_q    <= 1'b0;
			key_q    <= 32'd0;
			left_q   <= 16'd0;
			idx_q    <= 2'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			count_q  <= count_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
			key_q    <= key_d;
			left_q   <= left_d;
			idx_q    <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

endmodule

/* rtl/wfd_queue.sv */
// command queue between parser and output stage, a small circular buffer
// depends on wfd_pkg
module wfd_queue #(
	parameter int DEPTH = wfd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wfd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output wfd_pkg::cmd_t head_cmd
);
	import wfd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             buf_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign head_cmd = buf_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/wfd_emitter.sv */
// back end: unmasks payload bytes and holds the result in the output register
// depends on wfd_pkg
module wfd_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  wfd_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_data,
	output logic [5:0]    out_user,
	output logic          out_last
);
	import wfd_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic [5:0] user_q;
	logic       last_q;

	// refill whenever the register is empty or being drained this cycle
	assign q_pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_cmd.raw ^ q_cmd.key;
			user_q <= {q_cmd.opcode, q_cmd.kind};
			last_q <= q_cmd.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

endmodule

/* rtl/websocket_frame_deframer.sv */
// top level of the websocket frame deframer: parser, command queue, output stage
// depends on wfd_pkg, wfd_parser, wfd_queue, wfd_emitter
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: received byte
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata, tuser, tlast
//  cfg       in         cfg_we                        cfg_wdata: max payload length
//
// one byte per cycle in while the queue has room, at most one result per cycle
// out; a byte that makes a result needs one queue slot; the result is written
// into the queue, then into the output register, and tvalid rises after that
// arst_n clears the parser to the first header byte and max payload to 65535
// the parser stalls only when the queue is full; after an error input is
// drained with tready high and no results until reset
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = wfd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [5:0]  m_axis_tuser,   // [1:0] result_kind, [5:2] frame_opcode
	output logic        m_axis_tlast
);
	import wfd_pkg::*;

	logic q_push;
	cmd_t q_in;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	wfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_in)
	);

	wfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_cmd (q_head)
	);

	wfd_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

/* sim/websocket_frame_deframer_tb.sv */
// self-checking bench for websocket_frame_deframer: directed header forms, then random frames
// depends on wfd_pkg and the rtl of the block; the byte-level frame parser is modeled here
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
	import wfd_pkg::*;

	localparam logic [6:0] LEN7_EXT8 = 7'd127;
	localparam int STALL_LIMIT = 4000;
	localparam int RX_HOLD_CYCLES = 300;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] op;
		logic       last;
	} frame_res_t;

	typedef struct packed {
		logic [7:0] in_b;
		logic       typed;
		frame_res_t res;
	} stim_row_t;

	localparam frame_res_t NO_RES = '{KIND_DATA, 8'h00, 4'h0, 1'b0};

	// empty text frame, masked empty binary, close with status bytes, 8-byte length with key
	localparam stim_row_t DIR_ROWS [27] = '{
		'{8'h81, 1'b0, NO_RES},
		'{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, OP_TEXT, 1'b1}},
		'{8'h82, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES},
		'{8'h11, 1'b0, NO_RES},
		'{8'h22, 1'b0, NO_RES},
		'{8'h33, 1'b0, NO_RES},
		'{8'h44, 1'b1, '{KIND_EMPTY, 8'h00, OP_BIN, 1'b1}},
		'{8'h88, 1'b0, NO_RES},
		'{8'h02, 1'b0, NO_RES},
		'{8'h03, 1'b1, '{KIND_DATA, 8'h03, OP_CLOSE, 1'b0}},
		'{8'hE8, 1'b1, '{KIND_DATA, 8'hE8, OP_CLOSE, 1'b1}},
		'{8'h70, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'hFF, 1'b1, '{KIND_DATA, 8'h00, OP_CONT, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0000;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [5:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// parser model state
	phase_t      prs_phase = PH_HDR1;
	logic [3:0]  prs_op = 4'h0;
	logic        prs_masked = 1'b0;
	logic [2:0]  prs_field_cnt = 3'd0;
	logic [15:0] prs_len = 16'h0000;
	logic        prs_len_ovf = 1'b0;
	logic [31:0] prs_key = 32'h0;
	logic [15:0] prs_left = 16'h0000;
	logic [1:0]  prs_key_idx = 2'd0;
	logic [15:0] max_len = MAX_PAYLOAD_RST;

	frame_res_t  frame_results_q[$];
	int unsigned mismatch_cnt = 0;
	int unsigned bytes_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;

	websocket_frame_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// header complete: start payload or report an empty frame
	function automatic bit start_payload(output frame_res_t r);
		prs_key_idx = 2'd0;
		prs_left = prs_len;
		if (prs_left == 16'h0000) begin
			prs_phase = PH_HDR1;
			r = '{KIND_EMPTY, 8'h00, prs_op, 1'b1};
			return 1'b1;
		end
		prs_phase = PH_DATA;
		return 1'b0;
	endfunction

	function automatic bit check_length(output frame_res_t r);
		if (prs_len_ovf || prs_len > max_len) begin
			prs_phase = PH_ERR;
			r = '{KIND_LEN, 8'h00, prs_op, 1'b1};
			return 1'b1;
		end
		prs_key = 32'h0;
		if (prs_masked) begin
			prs_field_cnt = KEY_CNT;
			prs_phase = PH_KEY;
			return 1'b0;
		end
		return start_payload(r);
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output frame_res_t r);
		logic [3:0] op;
		logic [7:0] kb;
		r = NO_RES;
		case (prs_phase)
			PH_HDR1: begin
				op = b[3:0];
				if (op != OP_CONT && op != OP_TEXT && op != OP_BIN && op != OP_CLOSE) begin
					prs_phase = PH_ERR;
					r = '{KIND_BADOP, 8'h00, op, 1'b1};
					return 1'b1;
				end
				prs_op = op;
				prs_phase = PH_HDR2;
				return 1'b0;
			end
			PH_HDR2: begin
				prs_masked = b[7];
				prs_len = 16'h0000;
				prs_len_ovf = 1'b0;
				if (b[6:0] <= LEN7_MAX) begin
					prs_len = {9'd0, b[6:0]};
					return check_length(r);
				end
				// an 8-byte length starts from zero and wraps through all eight counts
				prs_field_cnt = (b[6:0] == LEN7_EXT2) ? EXT2_CNT : EXT8_CNT;
				prs_phase = PH_EXT;
				return 1'b0;
			end
			PH_EXT: begin
				if (prs_len[15:8] != 8'h00)
					prs_len_ovf = 1'b1;
				prs_len = {prs_len[7:0], b};
				prs_field_cnt = prs_field_cnt - 3'd1;
				if (prs_field_cnt == 3'd0)
					return check_length(r);
				return 1'b0;
			end
			PH_KEY: begin
				prs_key = {prs_key[23:0], b};
				prs_field_cnt = prs_field_cnt - 3'd1;
				if (prs_field_cnt == 3'd0)
					return start_payload(r);
				return 1'b0;
			end
			PH_DATA: begin
				kb = prs_masked ? prs_key[8 * (3 - prs_key_idx) +: 8] : 8'h00;
				prs_key_idx = prs_key_idx + 2'd1;
				prs_left = prs_left - 16'd1;
				r = '{KIND_DATA, b ^ kb, prs_op, prs_left == 16'h0000};
				if (prs_left == 16'h0000)
					prs_phase = PH_HDR1;
				return 1'b1;
			end
			default: begin
				prs_phase = PH_ERR;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b, input logic use_typed = 1'b0,
			input frame_res_t typed = NO_RES);
		frame_res_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (deframe_byte(b, r) && !use_typed)
			frame_results_q.push_back(r);
		if (use_typed)
			frame_results_q.push_back(typed);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (frame_results_q.size() != 0);
	endtask

	task automatic set_max_payload(input logic [15:0] value);
		wait_results_drained();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		max_len = value;
	endtask

	function automatic logic [3:0] pick_opcode();
		case ($urandom_range(3))
			0: return OP_CONT;
			1: return OP_TEXT;
			2: return OP_BIN;
			default: return OP_CLOSE;
		endcase
	endfunction

	task automatic send_frame(input logic [3:0] op, input len_form_t form,
			input logic [63:0] len_field, input int unsigned n_pay);
		logic [3:0] flags;
		logic       msk;
		logic [6:0] len7;
		flags = 4'($urandom_range(15));
		msk = 1'($urandom_range(1));
		case (form)
			LEN_SHORT: len7 = len_field[6:0];
			LEN_EXT16: len7 = LEN7_EXT2;
			default:   len7 = LEN7_EXT8;
		endcase
		send_byte({flags, op});
		send_byte({msk, len7});
		if (form == LEN_EXT16)
			for (int i = 1; i >= 0; i--) send_byte(len_field[8 * i +: 8]);
		else if (form == LEN_EXT64)
			for (int i = 7; i >= 0; i--) send_byte(len_field[8 * i +: 8]);
		if (msk)
			repeat (4) send_byte(8'($urandom));
		repeat (n_pay) send_byte(8'($urandom));
	endtask

	// mostly short payloads, some empty, some up to the cap, some exactly at the cap (configured maximum, at most 300)
	task automatic run_segment(input int unsigned n_bytes);
		int unsigned start_cnt, len, cap, roll;
		len_form_t form;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < n_bytes) begin
			cap = (max_len < 300) ? max_len : 300;
			roll = $urandom_range(99);
			if (cap == 0 || roll < 10)
				len = 0;
			else if (roll < 70)
				len = $urandom_range((cap < 16) ? cap : 16, 1);
			else if (roll < 92)
				len = $urandom_range(cap, 1);
			else
				len = cap;
			roll = $urandom_range(99);
			if (len <= LEN7_MAX)
				form = (roll < 60) ? LEN_SHORT : (roll < 85) ? LEN_EXT16 : LEN_EXT64;
			else
				form = (roll < 70) ? LEN_EXT16 : LEN_EXT64;
			send_frame(pick_opcode(), form, 64'(len), len);
		end
	endtask

	// receiver: random back-pressure plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : check_results
		frame_res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (frame_results_q.size() == 0)
				flag_mismatch("result with nothing expected, tdata", m_axis_tdata, 0);
			else begin
				want = frame_results_q.pop_front();
				if (m_axis_tuser[1:0] != want.kind)
					flag_mismatch("result_kind", m_axis_tuser[1:0], want.kind);
				if (m_axis_tdata != want.data)
					flag_mismatch("out_byte", m_axis_tdata, want.data);
				if (m_axis_tuser[5:2] != want.op)
					flag_mismatch("frame_opcode", m_axis_tuser[5:2], want.op);
				if (m_axis_tlast != want.last)
					flag_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		logic [3:0]  nib;
		logic [63:0] big;
		int unsigned len;
		tx_idle_pct = 26;
		rx_idle_pct <= 74;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i])
			send_byte(DIR_ROWS[i].in_b, DIR_ROWS[i].typed, DIR_ROWS[i].res);

		// zero maximum: only empty frames pass
		set_max_payload(16'h0000);
		run_segment(15);
		set_max_payload(16'($urandom_range(300, 16)));
		run_segment(330);

		tx_idle_pct = 74;
		rx_idle_pct <= 26;
		set_max_payload(16'hFFFF);
		run_segment(170);
		wait_results_drained();
		run_segment(170);

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		set_max_payload(16'($urandom_range(200, 64)));
		// long receiver hold-off while a frame streams in, filling the queue
		hold_req <= ~hold_req;
		send_frame(pick_opcode(), LEN_SHORT, 64'd48, 48);
		run_segment(280);

		// any error is terminal, so exactly one closes the run
		case ($urandom_range(2))
			0: begin
				do nib = 4'($urandom_range(15));
				while (nib == OP_CONT || nib == OP_TEXT || nib == OP_BIN || nib == OP_CLOSE);
				send_byte({4'($urandom_range(15)), nib});
			end
			1: begin
				len = $urandom_range(1) ? int'(max_len) + 1 : $urandom_range(65535, int'(max_len) + 1);
				send_frame(pick_opcode(), (len <= LEN7_MAX) ? LEN_SHORT : LEN_EXT16, 64'(len), 0);
			end
			default: begin
				big = {$urandom, $urandom};
				big[16 + $urandom_range(47)] = 1'b1;
				send_frame(pick_opcode(), LEN_EXT64, big, 0);
			end
		endcase
		// discarded after the error
		repeat (16) send_byte(8'($urandom));

		wait_results_drained();
		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
